// File: rtl/etok_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the expression tokenizer.
// No dependencies; every other file of the block imports this package.
package etok_pkg;

  // Token kinds carried on token_kind.
  localparam logic [2:0] KIND_NUMBER   = 3'd0;
  localparam logic [2:0] KIND_NAME     = 3'd1;
  localparam logic [2:0] KIND_VARIABLE = 3'd2;
  localparam logic [2:0] KIND_LPAREN   = 3'd3;
  localparam logic [2:0] KIND_RPAREN   = 3'd4;
  localparam logic [2:0] KIND_OPERATOR = 3'd5;
  localparam logic [2:0] KIND_ERROR    = 3'd6;
  localparam logic [2:0] KIND_EOF      = 3'd7;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_VAR    = 8'h78;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;

  // Width of the kept count of a token.
  localparam int COUNT_W = 5;

  // Entries in the queue between the scanner and the result stage.
  localparam int QUEUE_DEPTH = 4;

  // One result item.
  typedef struct packed {
    logic [2:0] token_kind;
    logic       has_char;
    logic [7:0] value_char;
    logic       token_start;
    logic       token_end;
    logic       last;
  } result_t;

  // All results caused by one input item: one or two.
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } group_t;

endpackage

// File: rtl/etok_front.sv
`timescale 1ns / 1ps
// Scanner of the expression tokenizer: classifies each character, keeps the
// scan mode and kept count, and forms the zero, one or two results of the item.
// Depends on etok_pkg.
module etok_front #(
  parameter int BUFFER_BYTES = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       ch,
  output logic             group_valid,
  output etok_pkg::group_t group
);
  import etok_pkg::*;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_INT  = 2'd1;
  localparam logic [1:0] MODE_FRAC = 2'd2;
  localparam logic [1:0] MODE_NAME = 2'd3;

  localparam logic [COUNT_W-1:0] KEEP_MAX = COUNT_W'(BUFFER_BYTES - 1);

  logic [1:0]         scan_mode;
  logic [1:0]         scan_mode_next;
  logic [COUNT_W-1:0] kept_count;
  logic [COUNT_W-1:0] kept_count_next;

  logic    is_digit;
  logic    is_letter;
  logic    is_op;
  logic    close_v;
  logic    tok_v;
  result_t close_r;
  result_t tok_r;

  // Character classes.
  assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_letter = ((ch >= CH_LOW_A) && (ch <= CH_LOW_Z)) ||
                     ((ch >= CH_UP_A) && (ch <= CH_UP_Z));
  assign is_op     = (ch == CH_PLUS) || (ch == CH_MINUS) || (ch == CH_STAR) ||
                     (ch == CH_SLASH) || (ch == CH_CARET);

  // Scan step: an optional close of the open token, then the token result.
  always_comb begin
    logic [1:0]         mode;
    logic [COUNT_W-1:0] cnt;
    logic               cont;
    mode    = scan_mode;
    cnt     = kept_count;
    cont    = 1'b0;
    close_v = 1'b0;
    close_r = '0;
    tok_v   = 1'b0;
    tok_r   = '0;

    // A continuing number or name keeps the character while room is left.
    if (((mode == MODE_INT) || (mode == MODE_FRAC)) &&
        (is_digit || ((ch == CH_DOT) && (mode == MODE_INT)))) begin
      cont = 1'b1;
      tok_r.token_kind = KIND_NUMBER;
      if (ch == CH_DOT) begin
        mode = MODE_FRAC;
      end
    end else if ((mode == MODE_NAME) && is_letter) begin
      cont = 1'b1;
      tok_r.token_kind = KIND_NAME;
    end else if (mode != MODE_IDLE) begin
      close_v = 1'b1;
      close_r.token_kind = (mode == MODE_NAME) ? KIND_NAME : KIND_NUMBER;
      close_r.token_end  = 1'b1;
      mode = MODE_IDLE;
      cnt  = '0;
    end

    if (cont) begin
      if (cnt < KEEP_MAX) begin
        tok_v = 1'b1;
        tok_r.has_char    = 1'b1;
        tok_r.value_char  = ch;
        tok_r.token_start = (cnt == '0);
        cnt = cnt + 1'b1;
      end
    end else if (ch == CH_SPACE) begin
      tok_v = 1'b0;
    end else if (ch == CH_NUL) begin
      tok_v = 1'b1;
      tok_r.token_kind  = KIND_EOF;
      tok_r.token_start = 1'b1;
      tok_r.token_end   = 1'b1;
    end else if (is_digit || (is_letter && (ch != CH_VAR))) begin
      // Opens a number or a name; the first character always fits.
      tok_v = 1'b1;
      tok_r.token_kind  = is_digit ? KIND_NUMBER : KIND_NAME;
      tok_r.has_char    = 1'b1;
      tok_r.value_char  = ch;
      tok_r.token_start = 1'b1;
      mode = is_digit ? MODE_INT : MODE_NAME;
      cnt  = COUNT_W'(1);
    end else begin
      // One-character tokens, including errors.
      tok_v = 1'b1;
      tok_r.has_char    = 1'b1;
      tok_r.value_char  = ch;
      tok_r.token_start = 1'b1;
      tok_r.token_end   = 1'b1;
      if (ch == CH_VAR) begin
        tok_r.token_kind = KIND_VARIABLE;
      end else if (ch == CH_LPAREN) begin
        tok_r.token_kind = KIND_LPAREN;
      end else if (ch == CH_RPAREN) begin
        tok_r.token_kind = KIND_RPAREN;
      end else if (is_op) begin
        tok_r.token_kind = KIND_OPERATOR;
      end else begin
        tok_r.token_kind = KIND_ERROR;
      end
    end

    scan_mode_next  = mode;
    kept_count_next = cnt;
  end

  // Pack the results of the item; the final one carries last.
  always_comb begin
    group = '0;
    if (close_v) begin
      group.r0     = close_r;
      group.r1     = tok_r;
      group.two    = tok_v;
      group.r1.last = tok_v;
      group.r0.last = !tok_v;
    end else begin
      group.r0      = tok_r;
      group.r0.last = 1'b1;
    end
  end

  assign group_valid = accept && (close_v || tok_v);

  // Scanner state.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode  <= MODE_IDLE;
      kept_count <= '0;
    end else if (accept) begin
      scan_mode  <= scan_mode_next;
      kept_count <= kept_count_next;
    end
  end

endmodule

// File: rtl/etok_queue.sv
`timescale 1ns / 1ps
// Short queue of result groups between the scanner and the result stage.
// Depends on etok_pkg.
module etok_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  etok_pkg::group_t wr_data,
  output logic             full,
  input  logic             rd,
  output etok_pkg::group_t rd_data,
  output logic             empty
);
  import etok_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  group_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  // Storage of the groups.
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // The scanner never writes a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(wr && full))
    else $error("queue written while full");

  // The result stage never reads an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(rd && empty))
    else $error("queue read while empty");

  // The fill count grows by one on a write without a read.
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (wr && !rd) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not grow on a write");

endmodule

// File: rtl/etok_back.sv
`timescale 1ns / 1ps
// Result stage of the expression tokenizer: hands out the results of each
// queued group one at a time through an output register. Depends on etok_pkg.
module etok_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  etok_pkg::group_t  q_data,
  output logic              q_rd,
  input  logic              pop,
  output logic              empty,
  output etok_pkg::result_t res
);
  import etok_pkg::*;

  logic out_valid;
  logic sel;
  logic load;

  // A queued group loads a result whenever the register is free or being taken.
  assign load  = !q_empty && (!out_valid || pop);
  assign q_rd  = load && (sel || !q_data.two);
  assign empty = !out_valid;

  // Output register; payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      res <= sel ? q_data.r1 : q_data.r0;
    end
  end

  // Valid flag and position within the current group.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        sel       <= !sel && q_data.two;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The second result of a group is only pending while its group is queued.
  a_sel_has_group: assert property (@(posedge clk) disable iff (rst)
    sel |-> !q_empty)
    else $error("second result pending without a queued group");

endmodule

// File: rtl/expression_tokenizer_unit.sv
`timescale 1ns / 1ps
// Top level of the expression tokenizer. Depends on etok_pkg, etok_front,
// etok_queue and etok_back.
//
// Takes one character each clock cycle (push while full is low) and gives
// token results on the output queue interface, one result per cycle while
// pop is high. A character yields zero, one or two results; each is stored
// in the group queue, then in the output register, before it shows. The
// single output register sets the sustained rate: one result per cycle, so
// a character that closes a token and opens another gives its two results
// in turn. A four-entry group queue between scanner and output register
// absorbs such bursts and output stalls; full rises only when it is full.
module expression_tokenizer_unit #(
  parameter int BUFFER_BYTES = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] ch,
  input  logic       pop,
  output logic       empty,
  output logic [2:0] token_kind,
  output logic       has_char,
  output logic [7:0] value_char,
  output logic       token_start,
  output logic       token_end,
  output logic       last
);
  import etok_pkg::*;

  logic    accept;
  logic    group_valid;
  group_t  group;
  group_t  q_data;
  logic    q_empty;
  logic    q_rd;
  result_t res;

  assign accept = push && !full;

  // Scanner.
  etok_front #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .ch         (ch),
    .group_valid(group_valid),
    .group      (group)
  );

  // Group queue.
  etok_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (group_valid),
    .wr_data(group),
    .full   (full),
    .rd     (q_rd),
    .rd_data(q_data),
    .empty  (q_empty)
  );

  // Result stage.
  etok_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_empty(q_empty),
    .q_data (q_data),
    .q_rd   (q_rd),
    .pop    (pop),
    .empty  (empty),
    .res    (res)
  );

  assign token_kind  = res.token_kind;
  assign has_char    = res.has_char;
  assign value_char  = res.value_char;
  assign token_start = res.token_start;
  assign token_end   = res.token_end;
  assign last        = res.last;

endmodule

// File: tb/expression_tokenizer_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of expression_tokenizer_unit: pushes character streams,
// predicts every token result and checks each popped result field by field.
// Depends on etok_pkg and the tokenizer RTL.
module expression_tokenizer_unit_tb;
  import etok_pkg::*;

  localparam int BUFFER_BYTES = 32;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int MAX_REPORTS = 100;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_INT,
    SCAN_FRAC,
    SCAN_NAME
  } scan_mode_e;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic [7:0] ch = 8'h00;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic [2:0] token_kind;
  logic       has_char;
  logic [7:0] value_char;
  logic       token_start;
  logic       token_end;
  logic       last;

  // Scanner state mirrored by the predictor.
  scan_mode_e  scan_mode = SCAN_IDLE;
  int unsigned kept_count = 0;

  // Results caused by the character being scanned, and all results still owed.
  result_t char_results[$];
  result_t tokens_due[$];

  int mismatch_count = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  expression_tokenizer_unit #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .ch         (ch),
    .pop        (pop),
    .empty      (empty),
    .token_kind (token_kind),
    .has_char   (has_char),
    .value_char (value_char),
    .token_start(token_start),
    .token_end  (token_end),
    .last       (last)
  );

  // Free-running clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The run is cut off if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
  endfunction

  function automatic result_t make_result(logic [2:0] kind, logic has, logic [7:0] c,
                                          logic opens, logic closes);
    result_t r;
    r.token_kind  = kind;
    r.has_char    = has;
    r.value_char  = has ? c : 8'h00;
    r.token_start = opens;
    r.token_end   = closes;
    r.last        = 1'b0;
    return r;
  endfunction

  // A number or name character is kept until the token buffer is full.
  function void keep_char(logic [2:0] kind, logic [7:0] c);
    if (kept_count < BUFFER_BYTES - 1) begin
      char_results.push_back(make_result(kind, 1'b1, c, kept_count == 0, 1'b0));
      kept_count++;
    end
  endfunction

  // Works out the results of one accepted character and queues them.
  function void scan_char(logic [7:0] c);
    bit      consumed;
    result_t final_result;
    consumed = 1'b0;
    char_results = {};

    // An open number or name either takes the character or is closed by it.
    if (scan_mode == SCAN_INT || scan_mode == SCAN_FRAC) begin
      if (is_digit(c)) begin
        keep_char(KIND_NUMBER, c);
        consumed = 1'b1;
      end else if (c == CH_DOT && scan_mode == SCAN_INT) begin
        keep_char(KIND_NUMBER, c);
        scan_mode = SCAN_FRAC;
        consumed = 1'b1;
      end else begin
        char_results.push_back(make_result(KIND_NUMBER, 1'b0, 8'h00, 1'b0, 1'b1));
        scan_mode = SCAN_IDLE;
        kept_count = 0;
      end
    end else if (scan_mode == SCAN_NAME) begin
      if (is_letter(c)) begin
        keep_char(KIND_NAME, c);
        consumed = 1'b1;
      end else begin
        char_results.push_back(make_result(KIND_NAME, 1'b0, 8'h00, 1'b0, 1'b1));
        scan_mode = SCAN_IDLE;
        kept_count = 0;
      end
    end

    // Otherwise the character starts a token of its own.
    if (!consumed) begin
      if (c == CH_SPACE) begin
        // Spaces only separate tokens.
      end else if (c == CH_NUL) begin
        char_results.push_back(make_result(KIND_EOF, 1'b0, 8'h00, 1'b1, 1'b1));
      end else if (c == CH_VAR) begin
        char_results.push_back(make_result(KIND_VARIABLE, 1'b1, c, 1'b1, 1'b1));
      end else if (c == CH_LPAREN) begin
        char_results.push_back(make_result(KIND_LPAREN, 1'b1, c, 1'b1, 1'b1));
      end else if (c == CH_RPAREN) begin
        char_results.push_back(make_result(KIND_RPAREN, 1'b1, c, 1'b1, 1'b1));
      end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
                   c == CH_CARET) begin
        char_results.push_back(make_result(KIND_OPERATOR, 1'b1, c, 1'b1, 1'b1));
      end else if (is_digit(c)) begin
        kept_count = 0;
        keep_char(KIND_NUMBER, c);
        scan_mode = SCAN_INT;
      end else if (is_letter(c)) begin
        kept_count = 0;
        keep_char(KIND_NAME, c);
        scan_mode = SCAN_NAME;
      end else begin
        char_results.push_back(make_result(KIND_ERROR, 1'b1, c, 1'b1, 1'b1));
      end
    end

    // The final result of the character carries last.
    if (char_results.size() > 0) begin
      final_result = char_results.pop_back();
      final_result.last = 1'b1;
      char_results.push_back(final_result);
    end
    foreach (char_results[i]) tokens_due.push_back(char_results[i]);
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("ERROR cycle %0d: %s", cycle_count, what);
    end
  endtask

  // Compares one popped result with the oldest predicted one.
  task automatic check_token();
    result_t want;
    if (tokens_due.size() == 0) begin
      report_mismatch($sformatf("unpredicted result kind %0d char %02h", token_kind,
                                value_char));
      return;
    end
    want = tokens_due.pop_front();
    if (token_kind !== want.token_kind)
      report_mismatch($sformatf("token_kind %0d, want %0d", token_kind, want.token_kind));
    if (has_char !== want.has_char)
      report_mismatch($sformatf("has_char %0b, want %0b", has_char, want.has_char));
    if (value_char !== want.value_char)
      report_mismatch($sformatf("value_char %02h, want %02h", value_char, want.value_char));
    if (token_start !== want.token_start)
      report_mismatch($sformatf("token_start %0b, want %0b", token_start, want.token_start));
    if (token_end !== want.token_end)
      report_mismatch($sformatf("token_end %0b, want %0b", token_end, want.token_end));
    if (last !== want.last)
      report_mismatch($sformatf("last %0b, want %0b", last, want.last));
  endtask

  // Result side: check each accepted result, then choose whether to pop next cycle.
  always @(posedge clk) begin
    if (!rst && pop && !empty) check_token();
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Sends one character item, with random gaps ahead of it.
  task automatic send_char(logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    ch <= c;
    @(posedge clk);
    while (full) @(posedge clk);
    scan_char(c);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  function automatic logic [7:0] random_digit();
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] random_letter();
    if ($urandom_range(1)) return CH_LOW_A + 8'($urandom_range(25));
    return CH_UP_A + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] random_operator();
    case ($urandom_range(4))
      0: return CH_PLUS;
      1: return CH_MINUS;
      2: return CH_STAR;
      3: return CH_SLASH;
      default: return CH_CARET;
    endcase
  endfunction

  // Token lengths are mostly short, now and then past the end of the buffer.
  function automatic int random_length();
    if ($urandom_range(15) == 0) return $urandom_range(28, 40);
    return $urandom_range(1, 4);
  endfunction

  // Sends one token of a random kind; a few are noise or broken numbers.
  task automatic send_random_token();
    int pick;
    pick = $urandom_range(99);
    if (pick < 25) begin
      repeat (random_length()) send_char(random_digit());
      if ($urandom_range(1)) begin
        send_char(CH_DOT);
        repeat ($urandom_range(0, 3)) send_char(random_digit());
        if ($urandom_range(5) == 0) send_char(CH_DOT);
      end
    end else if (pick < 40) begin
      repeat (random_length()) send_char(random_letter());
    end else if (pick < 48) begin
      send_char(CH_VAR);
    end else if (pick < 58) begin
      send_char($urandom_range(1) ? CH_LPAREN : CH_RPAREN);
    end else if (pick < 73) begin
      send_char(random_operator());
    end else if (pick < 83) begin
      repeat ($urandom_range(1, 3)) send_char(CH_SPACE);
    end else if (pick < 93) begin
      send_char(8'($urandom_range(255)));
    end else begin
      send_char(CH_NUL);
    end
  endtask

  // Every token kind, the edges of the digit and letter ranges, a second dot,
  // high bytes and end of expression both with and without an open token.
  task automatic test_directed_tokens();
    send_char(CH_NUL);
    send_text("(x+9.5)*Az -0.1./Za^.");
    send_char(8'h80);
    send_char(8'hFF);
    send_text("7");
    send_char(CH_NUL);
  endtask

  // Tokens longer than the buffer; the dot dropped past the end still starts
  // the fraction, so the next dot is an error.
  task automatic test_full_token();
    for (int i = 0; i < 32; i++) send_char(CH_ZERO + 8'(i % 10));
    send_text(".5.");
    for (int i = 0; i < 33; i++) send_char(CH_LOW_A + 8'(i % 26));
    send_char(CH_LPAREN);
    send_char(CH_NUL);
  endtask

  // Random expressions, mostly well formed, each usually ended by a zero byte.
  task automatic test_random_expressions(int item_goal);
    int first_item;
    first_item = items_sent;
    while (items_sent - first_item < item_goal) begin
      send_random_token();
      if ($urandom_range(7) == 0) send_char(CH_NUL);
    end
    send_char(CH_NUL);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 36;
    recv_idle_pct = 56;
    test_directed_tokens();
    test_full_token();
    test_random_expressions(ITEMS_PER_PHASE);

    send_idle_pct = 56;
    recv_idle_pct = 36;
    test_random_expressions(ITEMS_PER_PHASE);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_expressions(ITEMS_PER_PHASE);
    push <= 1'b0;

    // Let every predicted result drain, then watch for stray ones.
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/etok_pkg.sv
rtl/etok_front.sv
rtl/etok_queue.sv
rtl/etok_back.sv
rtl/expression_tokenizer_unit.sv
tb/expression_tokenizer_unit_tb.sv
